// ===== design/indexed_min_heap_queue_assert.svh =====
// Assertion macros for the indexed min-heap queue.
// Used by the top level; no dependencies.
`ifndef INDEXED_MIN_HEAP_QUEUE_ASSERT_SVH
`define INDEXED_MIN_HEAP_QUEUE_ASSERT_SVH
`define IMHQ_ASSERT_IMPL(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define IMHQ_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== design/imhq_pkg.sv =====
// Package for the indexed min-heap queue: widths, codes, state type.
// No dependencies.
package imhq_pkg;
    localparam int CAPACITY_DEF = 256;
    localparam int KEY_BITS_DEF = 32;
    localparam int ID_W = 8;
    localparam int ID_COUNT = 256;
    localparam int WEIGHT_W = 32;
    localparam int STATUS_W = 3;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELMIN = 2'd1;
    localparam logic [1:0] ACT_DECKEY = 2'd2;
    localparam logic [1:0] ACT_PEEK = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_ID = 3'd3;
    localparam logic [2:0] ST_NOT_DECREASED = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK_RD, S_CHK, S_DEL, S_UP_RD, S_UP_ID, S_UP_CMP,
        S_DN_RD, S_DN_ID, S_DN_CMP, S_FIN, S_ROOT, S_ROOT_ID, S_ROOT_KEY, S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0] action;
        logic [ID_W-1:0] item_id;
        logic [WEIGHT_W-1:0] item_weight;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0] min_id;
        logic [WEIGHT_W-1:0] min_weight;
        logic [STATUS_W-1:0] status;
        logic queue_empty;
    } t_rsp;
endpackage

// ===== design/imhq_if.sv =====
// Valid/ready channel interface carrying one payload.
// Depends on no package; payload type is a parameter.
interface imhq_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/indexed_min_heap_queue.sv =====
// Indexed min-heap queue top level: heap memory and per-id slot/key memory.
// Depends on imhq_pkg, imhq_if and indexed_min_heap_queue_assert.svh.
//
// Usage: requests enter on i_req (action, item_id, item_weight) and each
// produces exactly one transaction on o_rsp (min_id, min_weight, status,
// queue_empty). One request is worked at a time. The sifted entry is held
// in registers while each level reads the neighbor slot, then the neighbor
// key, then compares and writes the neighbor back; the moving entry is
// written once at its final slot. All requests but delete-min read the
// root after any sift to report the minimum. The result is held until
// taken; a stalled receiver holds the block in its done state and
// i_req.ready stays low. The next request can be accepted in the cycle
// after the result is taken at the earliest.
// Reset clears the presence bits and the entry count; the memories are not
// cleared since no entry is read before it is written.
module indexed_min_heap_queue #(
    parameter int CAPACITY = imhq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = imhq_pkg::KEY_BITS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    imhq_if.sink i_req,
    imhq_if.source o_rsp
);
    import imhq_pkg::*;
    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = SW + KEY_BITS;

    logic [ID_W-1:0] heap_mem [CAPACITY];
    logic [EW-1:0] id_mem [ID_COUNT];
    logic [ID_COUNT-1:0] r_present;
    logic [CW-1:0] r_count;

    t_state r_state, n_state;
    t_req r_req;
    logic [ID_W-1:0] r_min_id;
    logic [WEIGHT_W-1:0] r_min_weight;
    logic [STATUS_W-1:0] r_status;
    logic [SW-1:0] r_k;
    logic [ID_W-1:0] r_mid;
    logic [KEY_BITS-1:0] r_mkey;
    logic [ID_W-1:0] r_id_c0, r_id_c1;
    logic [SW-1:0] r_c0;
    logic r_has_c1;

    logic [SW-1:0] hra_addr, hrb_addr;
    logic [ID_W-1:0] r_hra, r_hrb;
    logic [ID_W-1:0] ira_addr, irb_addr;
    logic [EW-1:0] r_ira, r_irb;
    logic mw_en;
    logic [SW-1:0] mw_slot;
    logic [ID_W-1:0] mw_id;
    logic [KEY_BITS-1:0] mw_key;

    logic [KEY_BITS-1:0] w_in, ira_key, irb_key, child_key;
    logic [SW-1:0] ira_slot, parent, child_slot;
    logic [CW:0] c0_wide, c1_wide;
    logic c0_in, c1_in, take_c1;
    logic [ID_W-1:0] child_id;
    logic [STATUS_W-1:0] chk_status;

    assign w_in = KEY_BITS'(r_req.item_weight);
    assign ira_key = r_ira[KEY_BITS-1:0];
    assign ira_slot = r_ira[EW-1:KEY_BITS];
    assign irb_key = r_irb[KEY_BITS-1:0];
    assign parent = (r_k - SW'(1)) >> 1;
    assign c0_wide = (CW+1)'({r_k, 1'b1});
    assign c1_wide = c0_wide + (CW+1)'(1);
    assign c0_in = c0_wide < (CW+1)'(r_count);
    assign c1_in = c1_wide < (CW+1)'(r_count);
    assign take_c1 = r_has_c1 && (ira_key > irb_key);
    assign child_key = take_c1 ? irb_key : ira_key;
    assign child_id = take_c1 ? r_id_c1 : r_id_c0;
    assign child_slot = take_c1 ? r_c0 + SW'(1) : r_c0;

    always_ff @(posedge i_clk) begin
        r_hra <= heap_mem[hra_addr];
        r_hrb <= heap_mem[hrb_addr];
        r_ira <= id_mem[ira_addr];
        r_irb <= id_mem[irb_addr];
        if (mw_en) begin
            heap_mem[mw_slot] <= mw_id;
            id_mem[mw_id] <= {mw_slot, mw_key};
        end
    end

    always_comb begin
        chk_status = ST_OK;
        case (r_req.action)
            ACT_INSERT: begin
                if (r_present[r_req.item_id]) chk_status = ST_ID;
                else if (r_count >= CW'(CAPACITY)) chk_status = ST_FULL;
            end
            ACT_DELMIN: begin
                if (r_count == '0) chk_status = ST_EMPTY;
            end
            ACT_DECKEY: begin
                if (!r_present[r_req.item_id]) chk_status = ST_ID;
                else if (w_in > ira_key) chk_status = ST_NOT_DECREASED;
            end
            default: begin
                if (r_count == '0) chk_status = ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        hra_addr = '0;
        hrb_addr = '0;
        ira_addr = r_req.item_id;
        irb_addr = r_mid;
        mw_en = 1'b0;
        mw_slot = r_k;
        mw_id = r_mid;
        mw_key = r_mkey;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) n_state = S_CHK_RD;
            end
            S_CHK_RD: begin
                hrb_addr = SW'(r_count - CW'(1));
                n_state = S_CHK;
            end
            S_CHK: begin
                ira_addr = r_hra;
                irb_addr = r_hrb;
                case (r_req.action)
                    ACT_INSERT: n_state = (chk_status == ST_OK) ? S_UP_RD : S_ROOT;
                    ACT_DELMIN: n_state = (chk_status == ST_OK) ? S_DEL : S_DONE;
                    ACT_DECKEY: n_state = (chk_status == ST_OK) ? S_UP_RD : S_ROOT;
                    default: n_state = S_ROOT;
                endcase
            end
            S_DEL: begin
                n_state = (r_count == '0) ? S_DONE : S_DN_RD;
            end
            S_UP_RD: begin
                hra_addr = parent;
                n_state = (r_k == '0) ? S_FIN : S_UP_ID;
            end
            S_UP_ID: begin
                ira_addr = r_hra;
                n_state = S_UP_CMP;
            end
            S_UP_CMP: begin
                if (ira_key > r_mkey) begin
                    mw_en = 1'b1;
                    mw_id = r_id_c0;
                    mw_key = ira_key;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DN_RD: begin
                hra_addr = SW'(c0_wide);
                hrb_addr = c1_in ? SW'(c1_wide) : SW'(c0_wide);
                n_state = c0_in ? S_DN_ID : S_FIN;
            end
            S_DN_ID: begin
                ira_addr = r_hra;
                irb_addr = r_hrb;
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (r_mkey > child_key) begin
                    mw_en = 1'b1;
                    mw_id = child_id;
                    mw_key = child_key;
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                mw_en = 1'b1;
                n_state = (r_req.action == ACT_DELMIN) ? S_DONE : S_ROOT;
            end
            S_ROOT: begin
                n_state = (r_count == '0) ? S_DONE : S_ROOT_ID;
            end
            S_ROOT_ID: begin
                ira_addr = r_hra;
                n_state = S_ROOT_KEY;
            end
            S_ROOT_KEY: n_state = S_DONE;
            S_DONE: begin
                if (o_rsp.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) r_req <= i_req.data;
                end
                S_CHK: begin
                    r_status <= chk_status;
                    r_min_weight <= '0;
                    r_min_id <= (r_req.action == ACT_DELMIN && chk_status == ST_OK) ?
                        r_hra : '0;
                    r_mid <= (r_req.action == ACT_DELMIN) ? r_hrb : r_req.item_id;
                    r_mkey <= w_in;
                    if (chk_status == ST_OK) begin
                        case (r_req.action)
                            ACT_INSERT: begin
                                r_present[r_req.item_id] <= 1'b1;
                                r_count <= r_count + CW'(1);
                                r_k <= SW'(r_count);
                            end
                            ACT_DELMIN: begin
                                r_present[r_hra] <= 1'b0;
                                r_count <= r_count - CW'(1);
                                r_k <= '0;
                            end
                            ACT_DECKEY: begin
                                r_k <= ira_slot;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DEL: begin
                    r_min_weight <= WEIGHT_W'(ira_key);
                    r_mkey <= irb_key;
                end
                S_UP_ID: begin
                    r_id_c0 <= r_hra;
                end
                S_UP_CMP: begin
                    if (ira_key > r_mkey) r_k <= parent;
                end
                S_DN_RD: begin
                    r_c0 <= SW'(c0_wide);
                    r_has_c1 <= c1_in;
                end
                S_DN_ID: begin
                    r_id_c0 <= r_hra;
                    r_id_c1 <= r_hrb;
                end
                S_DN_CMP: begin
                    if (r_mkey > child_key) r_k <= child_slot;
                end
                S_ROOT_ID: begin
                    r_min_id <= r_hra;
                end
                S_ROOT_KEY: begin
                    r_min_weight <= WEIGHT_W'(ira_key);
                end
                default: ;
            endcase
        end
    end

    assign i_req.ready = i_rst_n && (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_DONE);
    assign o_rsp.data = {r_min_id, r_min_weight, r_status, (r_count == '0)};

    `include "indexed_min_heap_queue_assert.svh"
    `IMHQ_ASSERT_IMPL(a_excl, i_clk, i_rst_n, o_rsp.valid, !i_req.ready, "busy overlap")
    `IMHQ_ASSERT_IMPL(a_cnt, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "count over")
    `IMHQ_ASSERT_NEXT(a_take, i_clk, i_rst_n, i_req.valid && i_req.ready, r_state == S_CHK_RD,
        "no check after accept")
    `IMHQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_rsp.valid && !o_rsp.ready, o_rsp.valid,
        "result dropped while stalled")
endmodule

// ===== verif/indexed_min_heap_queue_tb.sv =====
// Testbench for the indexed min-heap queue: directed table, fill to capacity, then random
// requests, all checked against a behavioral heap. Depends on imhq_pkg, imhq_if and the top level.
module indexed_min_heap_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import imhq_pkg::*;

    localparam int CAP = 256;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    imhq_if #(.T(t_req)) req_if ();
    imhq_if #(.T(t_rsp)) rsp_if ();

    indexed_min_heap_queue dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_if.sink),
        .o_rsp(rsp_if.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // behavioral heap
    logic [7:0] hp_slot [CAP];
    int hp_pos [256];
    logic [31:0] hp_key [256];
    bit hp_live [256];
    int hp_count;

    t_rsp rsp_expected [$];
    int fail_count = 0;
    int checked_count = 0;
    int full_seen = 0;
    bit long_stall = 1'b0;

    function automatic logic [31:0] key_at(int s);
        return hp_key[hp_slot[s]];
    endfunction

    function automatic void swap_at(int a, int b);
        logic [7:0] t;
        t = hp_slot[a];
        hp_slot[a] = hp_slot[b];
        hp_slot[b] = t;
        hp_pos[hp_slot[a]] = a;
        hp_pos[hp_slot[b]] = b;
    endfunction

    function automatic void sift_up(int k);
        int p;
        while (k > 0) begin
            p = (k - 1) / 2;
            if (!(key_at(p) > key_at(k))) break;
            swap_at(k, p);
            k = p;
        end
    endfunction

    function automatic void sift_down(int k);
        int c;
        forever begin
            c = 2 * k + 1;
            if (c >= hp_count) break;
            if (c + 1 < hp_count && key_at(c) > key_at(c + 1)) c++;
            if (!(key_at(k) > key_at(c))) break;
            swap_at(k, c);
            k = c;
        end
    endfunction

    function automatic t_rsp heap_apply(t_req r);
        t_rsp o;
        bit removed;
        o = '0;
        removed = 1'b0;
        o.status = ST_OK;
        case (r.action)
            ACT_INSERT: begin
                if (hp_live[r.item_id]) begin
                    o.status = ST_ID;
                end else if (hp_count >= CAP) begin
                    o.status = ST_FULL;
                end else begin
                    hp_slot[hp_count] = r.item_id;
                    hp_pos[r.item_id] = hp_count;
                    hp_key[r.item_id] = r.item_weight;
                    hp_live[r.item_id] = 1'b1;
                    hp_count++;
                    sift_up(hp_count - 1);
                end
            end
            ACT_DELMIN: begin
                if (hp_count == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    o.min_id = hp_slot[0];
                    o.min_weight = hp_key[hp_slot[0]];
                    removed = 1'b1;
                    swap_at(0, hp_count - 1);
                    hp_count--;
                    hp_live[o.min_id] = 1'b0;
                    sift_down(0);
                end
            end
            ACT_DECKEY: begin
                if (!hp_live[r.item_id]) begin
                    o.status = ST_ID;
                end else if (r.item_weight > hp_key[r.item_id]) begin
                    o.status = ST_NOT_DECREASED;
                end else begin
                    hp_key[r.item_id] = r.item_weight;
                    sift_up(hp_pos[r.item_id]);
                end
            end
            default: begin
                if (hp_count == 0) o.status = ST_EMPTY;
            end
        endcase
        if (!removed && hp_count > 0) begin
            o.min_id = hp_slot[0];
            o.min_weight = hp_key[hp_slot[0]];
        end
        o.queue_empty = (hp_count == 0);
        return o;
    endfunction

    // directed table: action, id, weight, check flag, fixed expectation
    typedef struct {
        logic [1:0] act;
        logic [7:0] id;
        logic [31:0] w;
        bit fixed;
        t_rsp rsp;
    } t_row;

    t_row dir_rows [$];

    function automatic t_rsp mk(logic [7:0] id, logic [31:0] w, logic [2:0] st, logic e);
        t_rsp o;
        o.min_id = id;
        o.min_weight = w;
        o.status = st;
        o.queue_empty = e;
        return o;
    endfunction

    function automatic void add_row(logic [1:0] a, logic [7:0] id, logic [31:0] w,
                                    bit fx, t_rsp o);
        t_row r;
        r.act = a;
        r.id = id;
        r.w = w;
        r.fixed = fx;
        r.rsp = o;
        dir_rows.push_back(r);
    endfunction

    task automatic send_req(logic [1:0] a, logic [7:0] id, logic [31:0] w);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= '{action: a, item_id: id, item_weight: w};
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    // predict at the acceptance edge
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready)
            rsp_expected.push_back(heap_apply(req_if.data));
    end

    t_rsp fixed_q [$];
    bit fixed_flag_q [$];

    always @(posedge i_clk) begin
        t_rsp exp_r;
        t_rsp exp_fix;
        t_rsp got;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            checked_count++;
            if (got.status == ST_FULL) full_seen++;
            if (rsp_expected.size() == 0) begin
                $display("%0t unexpected transaction: actual %p", $time, got);
                fail_count++;
            end else begin
                exp_r = rsp_expected.pop_front();
                if (fixed_flag_q.size() > 0) begin
                    exp_fix = fixed_q.pop_front();
                    if (fixed_flag_q.pop_front() && got !== exp_fix) begin
                        $display("%0t table row expected %p actual %p", $time,
                                 exp_fix, got);
                        fail_count++;
                    end
                end
                if (got.min_id !== exp_r.min_id)
                    $display("%0t min_id expected %0d actual %0d", $time,
                             exp_r.min_id, got.min_id);
                if (got.min_weight !== exp_r.min_weight)
                    $display("%0t min_weight expected %h actual %h", $time,
                             exp_r.min_weight, got.min_weight);
                if (got.status !== exp_r.status)
                    $display("%0t status expected %0d actual %0d", $time,
                             exp_r.status, got.status);
                if (got.queue_empty !== exp_r.queue_empty)
                    $display("%0t queue_empty expected %0b actual %0b", $time,
                             exp_r.queue_empty, got.queue_empty);
                if (got !== exp_r) fail_count++;
            end
        end
    end

    // receiver: random stalls, one long hold-off while the heap is fed
    initial begin
        int wait_n;
        rsp_if.ready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (long_stall) begin
                wait_n = 400;
                long_stall = 1'b0;
            end else begin
                wait_n = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
            end
            if (wait_n > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_if.valid) @(posedge i_clk);
        end
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int pick;
        logic [1:0] a;
        logic [7:0] id;
        logic [31:0] w;
        req_if.valid = 1'b0;
        req_if.data = '0;
        for (int i = 0; i < 256; i++) hp_live[i] = 1'b0;
        hp_count = 0;

        add_row(ACT_PEEK, 8'd0, 32'd0, 1, mk(8'd0, 32'd0, ST_EMPTY, 1'b1));
        add_row(ACT_DELMIN, 8'd5, 32'd0, 1, mk(8'd0, 32'd0, ST_EMPTY, 1'b1));
        add_row(ACT_DECKEY, 8'd7, 32'd0, 1, mk(8'd0, 32'd0, ST_ID, 1'b1));
        add_row(ACT_INSERT, 8'd255, 32'hFFFF_FFFF, 1,
                mk(8'd255, 32'hFFFF_FFFF, ST_OK, 1'b0));
        add_row(ACT_INSERT, 8'd255, 32'd1, 1, mk(8'd255, 32'hFFFF_FFFF, ST_ID, 1'b0));
        add_row(ACT_INSERT, 8'd0, 32'd0, 1, mk(8'd0, 32'd0, ST_OK, 1'b0));
        add_row(ACT_INSERT, 8'd10, 32'h0001_8000, 0, '0);
        add_row(ACT_INSERT, 8'd11, 32'h0001_8000, 0, '0);
        add_row(ACT_INSERT, 8'd12, 32'hAAAA_5555, 0, '0);
        add_row(ACT_INSERT, 8'd13, 32'h5555_AAAA, 0, '0);
        add_row(ACT_DECKEY, 8'd12, 32'hFFFF_FFFF, 1, mk(8'd0, 32'd0, ST_NOT_DECREASED, 1'b0));
        add_row(ACT_DECKEY, 8'd11, 32'h0001_8000, 0, '0);
        add_row(ACT_DECKEY, 8'd255, 32'd0, 0, '0);
        add_row(ACT_PEEK, 8'd0, 32'd0, 0, '0);
        add_row(ACT_DELMIN, 8'd0, 32'd0, 0, '0);
        add_row(ACT_DELMIN, 8'd0, 32'd0, 0, '0);
        add_row(ACT_DELMIN, 8'd0, 32'd0, 0, '0);
        add_row(ACT_DECKEY, 8'd0, 32'd0, 0, '0);
        add_row(ACT_DELMIN, 8'd0, 32'd0, 0, '0);
        add_row(ACT_DELMIN, 8'd0, 32'd0, 0, '0);
        add_row(ACT_DELMIN, 8'd0, 32'd0, 0, '0);
        add_row(ACT_DELMIN, 8'd0, 32'd0, 1, mk(8'd0, 32'd0, ST_EMPTY, 1'b1));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            fixed_flag_q.push_back(dir_rows[i].fixed);
            fixed_q.push_back(dir_rows[i].rsp);
            send_req(dir_rows[i].act, dir_rows[i].id, dir_rows[i].w);
        end

        // fill to capacity under a long receiver stall, then a duplicate
        long_stall = 1'b1;
        for (int i = 0; i < 256; i++) send_req(ACT_INSERT, i[7:0], $urandom());
        send_req(ACT_INSERT, 8'd3, 32'd5);
        send_req(ACT_DELMIN, 8'd0, 32'd0);
        send_req(ACT_INSERT, 8'd200, 32'd0);
        send_req(ACT_PEEK, 8'd0, 32'd0);
        for (int i = 0; i < 40; i++) send_req(ACT_DELMIN, 8'd0, 32'd0);

        // random requests on a small id space so collisions are common
        for (int n = 0; n < 180; n++) begin
            pick = $urandom_range(0, 99);
            id = ($urandom_range(0, 4) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 40));
            case ($urandom_range(0, 3))
                0: w = $urandom_range(0, 15);
                1: w = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
                default: w = $urandom();
            endcase
            if (pick < 40) a = ACT_INSERT;
            else if (pick < 65) a = ACT_DELMIN;
            else if (pick < 90) a = ACT_DECKEY;
            else a = ACT_PEEK;
            if (a == ACT_DECKEY && hp_live[id] && $urandom_range(0, 3) != 0)
                w = hp_key[id] - 32'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 1000));
            send_req(a, id, w);
        end
        req_if.valid <= 1'b0;

        while (rsp_expected.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Checked %0d transactions, %0d full refusals, heap filled to capacity.",
                 checked_count, full_seen);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
